// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_CLK_RST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

// ----- rtl/core/dfs_pkg.sv -----
// ----------------------------------------------------------------------------
// DFS timestamp engine package
// Shared constants for the depth-first search timestamp engine.
// ----------------------------------------------------------------------------
package dfs_pkg;
    localparam int unsigned TIME_W = 8;
    localparam logic [1:0] COL_WHITE = 2'd0;
    localparam logic [1:0] COL_GRAY  = 2'd1;
    localparam logic [1:0] COL_BLACK = 2'd2;
    localparam logic ACT_EDGE = 1'b0;
    localparam logic ACT_RUN  = 1'b1;
    typedef logic [TIME_W-1:0] t_time;
endpackage

// ----- rtl/core/dfs_timestamp_engine.sv -----
// ----------------------------------------------------------------------------
// DFS timestamp engine
// Depth-first search over a stored adjacency matrix with an explicit stack.
// ----------------------------------------------------------------------------
// A run request searches the graph with a single neighbour test per cycle in the
// sequencer and a stack visit through S_FETCH and S_ROW, then emits N results,
// one per cycle while the master side is ready. Reset is synchronous and active
// low; it clears the matrix one row per cycle while no request is taken.
module dfs_timestamp_engine #(
    parameter int MAX_NODES = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [6:0]  i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // src_node[5:0], dst_node[11:6], zeros
    input  logic        s_axis_tuser,  // action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,  // node[5:0], discovery[13:6], finish[21:14]
    output logic        m_axis_tlast
);
    import dfs_pkg::*;
    localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int CW = AW + 1;
    localparam logic [2:0] S_CLR = 3'd0, S_IDLE = 3'd1, S_ROOT = 3'd2,
                           S_FETCH = 3'd3, S_SCAN = 3'd4, S_EMIT = 3'd5,
                           S_ROW = 3'd6;

    logic [MAX_NODES-1:0] r_adj [MAX_NODES];
    logic [MAX_NODES-1:0] r_seen;
    t_time       r_disc [MAX_NODES];
    t_time       r_fin  [MAX_NODES];
    logic [AW-1:0] r_stk_node [MAX_NODES];
    logic [CW-1:0] r_stk_scan [MAX_NODES];

    logic [2:0]    r_state;
    logic [6:0]    r_cnt_cfg;
    logic [CW-1:0] r_n, r_idx, r_depth, r_scan;
    logic [AW-1:0] r_v;
    logic [MAX_NODES-1:0] r_row;
    t_time         r_time;
    logic          r_oval, r_olast;
    logic [23:0]   r_odata;

    logic [CW-1:0] eff_n;
    logic [AW-1:0] src, dst;
    logic [AW-1:0] jj;
    logic [CW-1:0] top;
    always_comb begin
        eff_n = (r_cnt_cfg > 7'(MAX_NODES)) ? CW'(MAX_NODES) : CW'(r_cnt_cfg);
        src = AW'(s_axis_tdata[5:0]);
        dst = AW'(s_axis_tdata[11:6]);
        jj  = r_scan[AW-1:0];
        top = r_depth - 1'b1;
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_oval;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tlast  = r_olast;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR; r_cnt_cfg <= 7'd64; r_idx <= '0; r_depth <= '0;
            r_time <= '0; r_oval <= 1'b0;
        end else begin
            if (i_cfg_we) r_cnt_cfg <= i_cfg_wdata;
            if (r_oval && m_axis_tready && r_state != S_EMIT) r_oval <= 1'b0;
            case (r_state)
                S_CLR: begin
                    r_adj[r_idx[AW-1:0]] <= '0;
                    r_idx <= r_idx + 1'b1;
                    if (r_idx == CW'(MAX_NODES-1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        if (s_axis_tuser == ACT_EDGE) begin
                            if (7'(s_axis_tdata[5:0]) < 7'(eff_n)
                                && 7'(s_axis_tdata[11:6]) < 7'(eff_n))
                                r_adj[src][dst] <= 1'b1;
                        end else begin
                            r_n <= eff_n; r_idx <= '0; r_time <= '0; r_depth <= '0;
                            r_seen <= '0;
                            r_state <= S_ROOT;
                        end
                    end
                end
                S_ROOT: begin
                    if (r_idx >= r_n) begin
                        r_idx <= '0;
                        r_state <= (r_n == '0) ? S_IDLE : S_EMIT;
                    end else if (!r_seen[r_idx[AW-1:0]]) begin
                        r_seen[r_idx[AW-1:0]] <= 1'b1;
                        r_disc[r_idx[AW-1:0]] <= r_time + 1'b1;
                        r_time <= r_time + 1'b1;
                        r_stk_node[0] <= r_idx[AW-1:0];
                        r_stk_scan[0] <= '0;
                        r_depth <= CW'(1);
                        r_state <= S_FETCH;
                    end else r_idx <= r_idx + 1'b1;
                end
                S_FETCH: begin
                    if (r_depth == '0) begin
                        r_idx <= r_idx + 1'b1; r_state <= S_ROOT;
                    end else begin
                        r_v <= r_stk_node[top[AW-1:0]];
                        r_scan <= r_stk_scan[top[AW-1:0]];
                        r_state <= S_ROW;
                    end
                end
                S_ROW: begin
                    r_row <= r_adj[r_v];
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    if (r_scan >= r_n) begin
                        r_fin[r_v] <= r_time + 1'b1;
                        r_time <= r_time + 1'b1;
                        r_depth <= top;
                        r_state <= S_FETCH;
                    end else if (r_row[jj] && !r_seen[jj]) begin
                        r_stk_scan[top[AW-1:0]] <= r_scan + 1'b1;
                        r_seen[jj] <= 1'b1;
                        r_disc[jj] <= r_time + 1'b1;
                        r_time <= r_time + 1'b1;
                        r_stk_node[r_depth[AW-1:0]] <= jj;
                        r_stk_scan[r_depth[AW-1:0]] <= '0;
                        r_depth <= r_depth + 1'b1;
                        r_state <= S_FETCH;
                    end else r_scan <= r_scan + 1'b1;
                end
                S_EMIT: begin
                    if (!r_oval || m_axis_tready) begin
                        r_oval <= 1'b1;
                        r_odata <= {2'b00, r_fin[r_idx[AW-1:0]], r_disc[r_idx[AW-1:0]],
                                    6'(r_idx[AW-1:0])};
                        r_olast <= (r_idx + 1'b1 == r_n);
                        r_idx <= r_idx + 1'b1;
                        if (r_idx + 1'b1 == r_n) r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`include "assert_macros.svh"
    `ASSERT_CLK(a_ready_only_idle, i_clk, i_rst_n, s_axis_tready |-> r_state == S_IDLE, "ready")
    `ASSERT_CLK(a_depth_bound, i_clk, i_rst_n, r_depth <= CW'(MAX_NODES), "stack overflow")
    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n, (r_oval && !m_axis_tready) |=> $stable(r_odata), "hold")
endmodule

// ----- tb/sv/testbench.sv -----
// ----------------------------------------------------------------------------
// DFS timestamp engine testbench
// Loads edges and runs depth-first searches over several node counts and
// handshake phases. Each emitted result is checked against a local predictor.
// ----------------------------------------------------------------------------
module testbench;
    import dfs_pkg::*;

    typedef struct packed {
        logic [5:0] node;
        t_time      disc;
        t_time      fin;
        logic       last;
    } t_stamp;

    typedef struct {
        logic       act;
        logic [5:0] src;
        logic [5:0] dst;
        logic [6:0] cfg;
        bit         set_cfg;
        bit         typed;
        t_time      disc0;
        t_time      fin0;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [6:0]  i_cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;
    logic        m_axis_tlast;

    logic [63:0] adj_rows [64];
    logic [6:0]  node_cnt;
    t_stamp      stamp_queue [$];
    int          errors;
    int          idle_cycles;
    int          send_idle_pct;
    int          recv_stall_pct;

    dfs_timestamp_engine dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        errors++;
        $display("Mismatch in %s: got %0d, expected %0d", what, got, want);
    endtask

    function automatic int eff_count();
        return (node_cnt > 7'd64) ? 64 : int'(node_cnt);
    endfunction

    // Iterative search with an explicit path stack, ascending roots and neighbours.
    task automatic predict_search();
        int         n;
        int         clock;
        int         depth;
        int         v;
        int         j;
        bit         pushed;
        logic [1:0] colour [64];
        int         stk_node [64];
        int         stk_scan [64];
        t_time      disc [64];
        t_time      fin [64];
        t_stamp     s;
        n = eff_count();
        clock = 0;
        depth = 0;
        for (int r = 0; r < n; r++) colour[r] = COL_WHITE;
        for (int r = 0; r < n; r++) begin
            if (colour[r] != COL_WHITE) continue;
            colour[r] = COL_GRAY;
            clock++;
            disc[r] = t_time'(clock);
            stk_node[0] = r;
            stk_scan[0] = 0;
            depth = 1;
            while (depth > 0) begin
                v = stk_node[depth-1];
                pushed = 0;
                for (j = stk_scan[depth-1]; j < n; j++) begin
                    if (adj_rows[v][j] && colour[j] == COL_WHITE) begin
                        stk_scan[depth-1] = j + 1;
                        colour[j] = COL_GRAY;
                        clock++;
                        disc[j] = t_time'(clock);
                        stk_node[depth] = j;
                        stk_scan[depth] = 0;
                        depth++;
                        pushed = 1;
                        break;
                    end
                end
                if (!pushed) begin
                    colour[v] = COL_BLACK;
                    clock++;
                    fin[v] = t_time'(clock);
                    depth--;
                end
            end
        end
        for (int k = 0; k < n; k++) begin
            s.node = 6'(k);
            s.disc = disc[k];
            s.fin  = fin[k];
            s.last = (k + 1 == n);
            stamp_queue.push_back(s);
        end
    endtask

    task automatic send_request(input logic act, input logic [5:0] src, input logic [5:0] dst);
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= {4'd0, dst, src};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        if (act == ACT_RUN) begin
            predict_search();
        end else if (int'(src) < eff_count() && int'(dst) < eff_count()) begin
            adj_rows[src][dst] = 1'b1;
        end
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        s_axis_tvalid <= 1'b0;
        while (stamp_queue.size() != 0) @(posedge i_clk);
        while (guard < 20) begin
            @(posedge i_clk);
            guard++;
        end
    endtask

    task automatic write_count(input logic [6:0] val);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        node_cnt = val;
    endtask

    // Result checker and receiver stalls.
    always @(posedge i_clk) begin
        t_stamp got;
        t_stamp want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b1;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = {m_axis_tdata[5:0], m_axis_tdata[13:6], m_axis_tdata[21:14], m_axis_tlast};
                if (stamp_queue.size() == 0) begin
                    report_mismatch("unexpected result node", got.node, -1);
                end else begin
                    want = stamp_queue.pop_front();
                    if (got.node != want.node) report_mismatch("node", got.node, want.node);
                    if (got.disc != want.disc)
                        report_mismatch("discovery time", got.disc, want.disc);
                    if (got.fin != want.fin) report_mismatch("finish time", got.fin, want.fin);
                    if (got.last != want.last) report_mismatch("last", got.last, want.last);
                end
            end
            m_axis_tready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
        end
    end

    // Watchdog over cycles without any accepted request or result.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 40000) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    t_row directed [] = '{
        '{ACT_RUN,  6'd0,  6'd0,  7'd0,  1, 1, 8'd1, 8'd2},
        '{ACT_RUN,  6'd0,  6'd0,  7'd1,  1, 1, 8'd1, 8'd2},
        '{ACT_EDGE, 6'd0,  6'd0,  7'd0,  0, 0, 8'd0, 8'd0},
        '{ACT_RUN,  6'd0,  6'd0,  7'd0,  0, 1, 8'd1, 8'd2},
        '{ACT_EDGE, 6'd0,  6'd1,  7'd4,  1, 0, 8'd0, 8'd0},
        '{ACT_EDGE, 6'd1,  6'd2,  7'd0,  0, 0, 8'd0, 8'd0},
        '{ACT_EDGE, 6'd1,  6'd2,  7'd0,  0, 0, 8'd0, 8'd0},
        '{ACT_EDGE, 6'd2,  6'd0,  7'd0,  0, 0, 8'd0, 8'd0},
        '{ACT_EDGE, 6'd3,  6'd5,  7'd0,  0, 0, 8'd0, 8'd0},
        '{ACT_EDGE, 6'd63, 6'd0,  7'd0,  0, 0, 8'd0, 8'd0},
        '{ACT_RUN,  6'd0,  6'd0,  7'd0,  0, 1, 8'd1, 8'd6},
        '{ACT_RUN,  6'd0,  6'd0,  7'd0,  1, 0, 8'd0, 8'd0},
        '{ACT_EDGE, 6'd63, 6'd62, 7'd127,1, 0, 8'd0, 8'd0},
        '{ACT_EDGE, 6'd62, 6'd63, 7'd0,  0, 0, 8'd0, 8'd0},
        '{ACT_EDGE, 6'd42, 6'd21, 7'd0,  0, 0, 8'd0, 8'd0},
        '{ACT_EDGE, 6'd21, 6'd42, 7'd0,  0, 0, 8'd0, 8'd0},
        '{ACT_RUN,  6'd0,  6'd0,  7'd0,  0, 1, 8'd1, 8'd6},
        '{ACT_RUN,  6'd0,  6'd0,  7'd65, 1, 1, 8'd1, 8'd6},
        '{ACT_RUN,  6'd0,  6'd0,  7'd3,  1, 1, 8'd1, 8'd6}
    };

    initial begin
        t_stamp head;
        int     n;
        logic [5:0] a;
        logic [5:0] b;
        errors         = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        node_cnt       = 7'd64;
        for (int r = 0; r < 64; r++) adj_rows[r] = '0;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = ACT_EDGE;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[i]) begin
            if (directed[i].set_cfg) write_count(directed[i].cfg);
            send_request(directed[i].act, directed[i].src, directed[i].dst);
            // The first node of a run is always a root with the opening stamps.
            if (directed[i].typed && eff_count() > 0) begin
                head = stamp_queue[stamp_queue.size() - eff_count()];
                if (head.disc != directed[i].disc0)
                    report_mismatch("typed first discovery", head.disc, directed[i].disc0);
                if (head.fin != directed[i].fin0)
                    report_mismatch("typed first finish", head.fin, directed[i].fin0);
            end
        end

        for (int phase = 0; phase < 8; phase++) begin
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
                default: begin send_idle_pct = 18; recv_stall_pct = 18; end
            endcase
            if (phase == 7) write_count(7'd64);
            else if (phase == 6) write_count(7'd1);
            else write_count(7'($urandom_range(2, 16)));
            n = eff_count();
            for (int k = 0; k < 50; k++) begin
                if ($urandom_range(9) == 0) begin
                    send_request(ACT_RUN, 6'($urandom), 6'($urandom));
                end else if ($urandom_range(7) == 0) begin
                    send_request(ACT_EDGE, 6'($urandom), 6'($urandom));
                end else begin
                    a = 6'($urandom_range(n - 1));
                    b = 6'($urandom_range(n - 1));
                    send_request(ACT_EDGE, a, b);
                end
            end
            send_request(ACT_RUN, 6'($urandom), 6'($urandom));
        end

        drain();
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
